// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define FCB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FCB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/fcb_pkg.sv =====
// Shared widths, register indexes and helpers of the frame change bounding box.
// No dependencies.
`default_nettype none

package fcb_pkg;

    localparam int COORD_W   = 11;
    localparam int COUNT_W   = 23;
    localparam int PIXEL_W   = 24;
    localparam int PIXEL16_W = 16;
    localparam int MAX_DIM   = 2048;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = COORD_W;

    localparam logic MODE_24BIT = 1'b0;
    localparam logic MODE_16BIT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_MODE    = 3'd0,
        CFG_WINDOW_LEFT   = 3'd1,
        CFG_WINDOW_TOP    = 3'd2,
        CFG_WINDOW_RIGHT  = 3'd3,
        CFG_WINDOW_BOTTOM = 3'd4
    } cfg_reg_t;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Step a position, wrapping at the largest frame dimension.
    function automatic coord_t next_coord(input coord_t v);
        coord_t n;
        begin
            if (v == COORD_W'(MAX_DIM - 1))
            begin
                n = '0;
            end
            else
            begin
                n = v + 1'b1;
            end
            return n;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/frame_change_bounding_box_unit.sv =====
// Frame change bounding box: top level, the whole datapath.
// Depends on fcb_pkg.
//
// Takes one pair of co-located pixels per clock in raster order over the
// configured inclusive window and, on the window's last pixel, delivers one
// beat carrying the count of differing pixels, a change flag and the
// bounding box of the changes (the window itself when nothing differed).
// Each pixel beat goes through an input register and, for the last pixel,
// into a result register, which presents the result beat. The input stalls
// only when the last pixel of a window meets a result that is still waiting
// downstream; otherwise one beat per clock is taken. Writing a window
// register restarts the scan; writing the pixel mode does not.
`default_nettype none

module frame_change_bounding_box_unit
    import fcb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [PIXEL_W-1:0]   old_pixel,
    input  wire logic [PIXEL_W-1:0]   new_pixel,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [COUNT_W-1:0]        changed_count,
    output logic                      any_change,
    output logic [COORD_W-1:0]        box_left,
    output logic [COORD_W-1:0]        box_top,
    output logic [COORD_W-1:0]        box_right,
    output logic [COORD_W-1:0]        box_bottom
);

    // Configuration
    logic   mode_reg;
    coord_t win_left_reg, win_top_reg, win_right_reg, win_bottom_reg;

    // Scan state
    coord_t col_reg, row_reg, col_next, row_next;
    count_t count_reg, count_next;
    logic   seen_reg, seen_next;
    coord_t min_col_reg, max_col_reg, min_row_reg, max_row_reg;
    coord_t min_col_next, max_col_next, min_row_next, max_row_next;

    // Input stage
    logic               s1_valid_reg, s1_valid_next;
    logic [PIXEL_W-1:0] s1_old_reg, s1_new_reg;

    // Result stage
    logic   out_valid_reg, out_valid_next;
    count_t res_count_reg;
    logic   res_any_reg;
    coord_t res_left_reg, res_top_reg, res_right_reg, res_bottom_reg;

    logic               in_take, out_free, s1_go, s1_last, last_col, hit;
    logic               win_write;
    logic [PIXEL_W-1:0] diff;
    count_t             count_upd;
    logic               seen_upd;
    coord_t             min_col_upd, max_col_upd, min_row_upd, max_row_upd;
    coord_t             new_left, new_top;

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    assign last_col = (col_reg == win_right_reg);
    assign s1_last  = last_col && (row_reg == win_bottom_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && (!s1_last || out_free);
    assign in_stall = s1_valid_reg && s1_last && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_go);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && s1_last)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Compare and accumulate
    // ---------------------------------------------------------------
    assign diff = s1_old_reg ^ s1_new_reg;
    assign hit  = (mode_reg == MODE_16BIT) ? (|diff[PIXEL16_W-1:0]) : (|diff);

    assign count_upd   = (hit && (count_reg != '1)) ? count_reg + 1'b1 : count_reg;
    assign seen_upd    = seen_reg | hit;
    assign min_col_upd = (hit && (col_reg < min_col_reg)) ? col_reg : min_col_reg;
    assign max_col_upd = (hit && (col_reg > max_col_reg)) ? col_reg : max_col_reg;
    assign min_row_upd = (hit && (row_reg < min_row_reg)) ? row_reg : min_row_reg;
    assign max_row_upd = (hit && (row_reg > max_row_reg)) ? row_reg : max_row_reg;

    assign win_write = cfg_write && (cfg_index == CFG_WINDOW_LEFT ||
                                     cfg_index == CFG_WINDOW_TOP ||
                                     cfg_index == CFG_WINDOW_RIGHT ||
                                     cfg_index == CFG_WINDOW_BOTTOM);
    assign new_left  = (cfg_index == CFG_WINDOW_LEFT) ? cfg_data : win_left_reg;
    assign new_top   = (cfg_index == CFG_WINDOW_TOP)  ? cfg_data : win_top_reg;

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        count_next   = count_reg;
        seen_next    = seen_reg;
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        priority if (win_write || (s1_go && s1_last))
        begin
            // restart the scan from the (possibly new) window origin
            col_next     = win_write ? new_left : win_left_reg;
            row_next     = win_write ? new_top  : win_top_reg;
            count_next   = '0;
            seen_next    = 1'b0;
            min_col_next = '1;
            max_col_next = '0;
            min_row_next = '1;
            max_row_next = '0;
        end
        else if (s1_go)
        begin
            count_next   = count_upd;
            seen_next    = seen_upd;
            min_col_next = min_col_upd;
            max_col_next = max_col_upd;
            min_row_next = min_row_upd;
            max_row_next = max_row_upd;
            if (last_col)
            begin
                col_next = win_left_reg;
                row_next = next_coord(row_reg);
            end
            else
            begin
                col_next = next_coord(col_reg);
            end
        end
        else
        begin
            // hold the scan state
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_24BIT;
            win_left_reg   <= '0;
            win_top_reg    <= '0;
            win_right_reg  <= '1;
            win_bottom_reg <= '1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PIXEL_MODE:    mode_reg       <= cfg_data[0];
                CFG_WINDOW_LEFT:   win_left_reg   <= cfg_data;
                CFG_WINDOW_TOP:    win_top_reg    <= cfg_data;
                CFG_WINDOW_RIGHT:  win_right_reg  <= cfg_data;
                CFG_WINDOW_BOTTOM: win_bottom_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            min_col_reg   <= '1;
            max_col_reg   <= '0;
            min_row_reg   <= '1;
            max_row_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            min_col_reg   <= min_col_next;
            max_col_reg   <= max_col_next;
            min_row_reg   <= min_row_next;
            max_row_reg   <= max_row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_old_reg <= old_pixel;
            s1_new_reg <= new_pixel;
        end
        if (s1_go && s1_last)
        begin
            res_count_reg  <= count_upd;
            res_any_reg    <= seen_upd;
            res_left_reg   <= seen_upd ? min_col_upd : win_left_reg;
            res_top_reg    <= seen_upd ? min_row_upd : win_top_reg;
            res_right_reg  <= seen_upd ? max_col_upd : win_right_reg;
            res_bottom_reg <= seen_upd ? max_row_upd : win_bottom_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign changed_count = res_count_reg;
    assign any_change    = res_any_reg;
    assign box_left      = res_left_reg;
    assign box_top       = res_top_reg;
    assign box_right     = res_right_reg;
    assign box_bottom    = res_bottom_reg;

endmodule

`default_nettype wire

// ===== src/fcb_checker.sv =====
// Port-level checks on the frame change bounding box, and the bind that attaches them.
// Depends on fcb_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module fcb_checker
    import fcb_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [COUNT_W-1:0] changed_count,
    input wire logic               any_change,
    input wire logic [COORD_W-1:0] box_left,
    input wire logic [COORD_W-1:0] box_top,
    input wire logic [COORD_W-1:0] box_right,
    input wire logic [COORD_W-1:0] box_bottom
);

    // a held result beat keeps its count, flag, left edge and bottom edge
    `FCB_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(changed_count) && $stable(any_change) && $stable(box_left) && $stable(box_bottom), "result beat changed while stalled")

    // input backs up only behind a waiting result
    `FCB_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled with no waiting result")

    // the change flag agrees with the count
    `FCB_ASSERT(a_flag_count, clk, rst_n, out_valid |-> (any_change == (changed_count != '0)), "change flag disagrees with count")

    // a box built from changes is never inverted
    `FCB_ASSERT(a_box_order, clk, rst_n, out_valid && any_change |-> (box_left <= box_right) && (box_top <= box_bottom), "inverted bounding box")

endmodule

bind frame_change_bounding_box_unit fcb_checker u_fcb_checker (.*);

`default_nettype wire

// ===== test/fcb_box_checker.sv =====
// Checker for the frame change bounding box: watches the config port and both
// pixel and result channels, predicts each window's box and compares it.
// Depends on fcb_pkg for widths, register indexes and pixel mode codes.
module fcb_box_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [fcb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcb_pkg::CFG_W-1:0]     cfg_data,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [fcb_pkg::PIXEL_W-1:0]   old_pixel,
    input  logic [fcb_pkg::PIXEL_W-1:0]   new_pixel,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [fcb_pkg::COUNT_W-1:0]   changed_count,
    input  logic                         any_change,
    input  logic [fcb_pkg::COORD_W-1:0]   box_left,
    input  logic [fcb_pkg::COORD_W-1:0]   box_top,
    input  logic [fcb_pkg::COORD_W-1:0]   box_right,
    input  logic [fcb_pkg::COORD_W-1:0]   box_bottom,
    output int                           errors,
    output int                           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import fcb_pkg::*;

    typedef struct packed {
        count_t count;
        logic   changed;
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
    } box_beat_t;

    // Configuration copy
    logic   mode_16;
    coord_t win_left;
    coord_t win_top;
    coord_t win_right;
    coord_t win_bottom;

    // Scan state
    coord_t col_at;
    coord_t row_at;
    count_t tally;
    logic   any_seen;
    coord_t lo_col;
    coord_t hi_col;
    coord_t lo_row;
    coord_t hi_row;

    box_beat_t pending_boxes[$];
    int        fails;

    function automatic coord_t advance(input coord_t c);
        return coord_t'((int'(c) + 1) % MAX_DIM);
    endfunction

    task automatic restart_scan();
        col_at   = win_left;
        row_at   = win_top;
        tally    = '0;
        any_seen = 1'b0;
        lo_col   = '1;
        hi_col   = '0;
        lo_row   = '1;
        hi_row   = '0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (cfg_reg_t'(idx))
            CFG_PIXEL_MODE:    mode_16 = data[0];
            CFG_WINDOW_LEFT:   win_left = data;
            CFG_WINDOW_TOP:    win_top = data;
            CFG_WINDOW_RIGHT:  win_right = data;
            CFG_WINDOW_BOTTOM: win_bottom = data;
            default: ;
        endcase
        // Any window write restarts the scan; the pixel mode does not
        case (cfg_reg_t'(idx))
            CFG_WINDOW_LEFT, CFG_WINDOW_TOP, CFG_WINDOW_RIGHT, CFG_WINDOW_BOTTOM:
                restart_scan();
            default: ;
        endcase
    endtask

    task automatic count_pixel(input logic [PIXEL_W-1:0] prev, input logic [PIXEL_W-1:0] curr);
        logic [PIXEL_W-1:0] differ;
        logic               end_col;
        logic               end_row;
        box_beat_t          res;
        differ = prev ^ curr;
        if (mode_16 == MODE_16BIT)
        begin
            differ[PIXEL_W-1:PIXEL16_W] = '0;
        end
        end_col = (col_at == win_right);
        end_row = (row_at == win_bottom);
        if (differ != '0)
        begin
            if (tally != '1)
            begin
                tally = tally + 1'b1;
            end
            any_seen = 1'b1;
            if (col_at < lo_col) lo_col = col_at;
            if (col_at > hi_col) hi_col = col_at;
            if (row_at < lo_row) lo_row = row_at;
            if (row_at > hi_row) hi_row = row_at;
        end
        if (end_col && end_row)
        begin
            res.count   = tally;
            res.changed = any_seen;
            if (any_seen)
            begin
                res.left   = lo_col;
                res.top    = lo_row;
                res.right  = hi_col;
                res.bottom = hi_row;
            end
            else
            begin
                res.left   = win_left;
                res.top    = win_top;
                res.right  = win_right;
                res.bottom = win_bottom;
            end
            pending_boxes = {pending_boxes, res};
            restart_scan();
        end
        else if (end_col)
        begin
            col_at = win_left;
            row_at = advance(row_at);
        end
        else
        begin
            col_at = advance(col_at);
        end
    endtask

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        box_beat_t want;
        if (!rst_n)
        begin
            mode_16    = MODE_24BIT;
            win_left   = '0;
            win_top    = '0;
            win_right  = '1;
            win_bottom = '1;
            restart_scan();
            pending_boxes.delete();
            fails = 0;
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                write_reg(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                count_pixel(old_pixel, new_pixel);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_boxes.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual count %0d box %0d %0d %0d %0d",
                             $time, changed_count, box_left, box_top, box_right, box_bottom);
                    fails++;
                end
                else
                begin
                    want = pending_boxes.pop_front();
                    check_field("changed_count", want.count, changed_count);
                    check_field("any_change", want.changed, any_change);
                    check_field("box_left", want.left, box_left);
                    check_field("box_top", want.top, box_top);
                    check_field("box_right", want.right, box_right);
                    check_field("box_bottom", want.bottom, box_bottom);
                end
            end
            errors      <= fails;
            outstanding <= pending_boxes.size();
        end
    end

endmodule

// ===== test/tb_frame_change_bounding_box_unit.sv =====
// Testbench top for frame_change_bounding_box_unit: drives pixel pairs and
// register writes, stalls the result side, and reports the verdict.
// Depends on fcb_pkg, the block itself and fcb_box_checker.
module tb_frame_change_bounding_box_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import fcb_pkg::*;

    localparam int RANDOM_PAIRS  = 700;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int WRAP_SPAN     = 32;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [PIXEL_W-1:0]   old_pixel = '0;
    logic [PIXEL_W-1:0]   new_pixel = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [COUNT_W-1:0]   changed_count;
    logic                 any_change;
    logic [COORD_W-1:0]   box_left;
    logic [COORD_W-1:0]   box_top;
    logic [COORD_W-1:0]   box_right;
    logic [COORD_W-1:0]   box_bottom;

    int check_fails;
    int outstanding;
    int cycle_count = 0;
    int stall_run = 0;
    int stall_pick;
    bit gappy = 1'b0;

    frame_change_bounding_box_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .old_pixel(old_pixel),
        .new_pixel(new_pixel),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .changed_count(changed_count),
        .any_change(any_change),
        .box_left(box_left),
        .box_top(box_top),
        .box_right(box_right),
        .box_bottom(box_bottom)
    );

    fcb_box_checker u_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .old_pixel(old_pixel),
        .new_pixel(new_pixel),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .changed_count(changed_count),
        .any_change(any_change),
        .box_left(box_left),
        .box_top(box_top),
        .box_right(box_right),
        .box_bottom(box_bottom),
        .errors(check_fails),
        .outstanding(outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: runs of free flow and stalls, mostly short, a few long
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 40)
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(1, 30);
            end
            else if (stall_pick < 85)
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(1, 3);
            end
            else if (stall_pick < 95)
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(50, 200);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(15, 40);
            end
        end
        else
        begin
            stall_run <= stall_run - 1;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gappy || roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pair(input logic [PIXEL_W-1:0] prev, input logic [PIXEL_W-1:0] curr);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        old_pixel <= prev;
        new_pixel <= curr;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Hold off until every expected box has come out, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input bit window_too, input logic mode,
                                  input coord_t l, input coord_t t,
                                  input coord_t r, input coord_t b);
        cfg_write <= 1'b1;
        cfg_index <= CFG_PIXEL_MODE;
        cfg_data  <= CFG_W'(mode);
        @(posedge clk);
        if (window_too)
        begin
            cfg_index <= CFG_WINDOW_LEFT;
            cfg_data  <= l;
            @(posedge clk);
            cfg_index <= CFG_WINDOW_TOP;
            cfg_data  <= t;
            @(posedge clk);
            cfg_index <= CFG_WINDOW_RIGHT;
            cfg_data  <= r;
            @(posedge clk);
            cfg_index <= CFG_WINDOW_BOTTOM;
            cfg_data  <= b;
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic send_random_pairs(input int count, input int density);
        logic [PIXEL_W-1:0] prev;
        logic [PIXEL_W-1:0] curr;
        int                 roll;
        for (int i = 0; i < count; i++)
        begin
            prev = PIXEL_W'($urandom());
            roll = $urandom_range(0, 99);
            if (roll < density)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    curr = prev ^ (PIXEL_W'(1) << $urandom_range(0, PIXEL_W - 1));
                end
                else
                begin
                    curr = PIXEL_W'($urandom());
                end
            end
            else if (roll < density + 10)
            begin
                // differ only above bit 15: a change in 24-bit mode alone
                curr = prev ^ {8'($urandom_range(1, 255)), 16'h0000};
            end
            else
            begin
                curr = prev;
            end
            if ($urandom_range(0, 199) == 0)
            begin
                settle();
            end
            send_pair(prev, curr);
        end
    endtask

    initial
    begin
        int     pairs_sent;
        int     phase;
        int     density;
        int     cols;
        int     rows;
        int     frames;
        int     n;
        logic   mode;
        coord_t l;
        coord_t t;
        coord_t r;
        coord_t b;
        int     densities[4];

        densities = '{0, 3, 25, 90};
        pairs_sent = 0;
        phase = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One-pixel window at the far corner: unchanged, then changed, twice over
        apply_settings(1'b1, MODE_24BIT, '1, '1, '1, '1);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'h000000, 24'hFFFFFF);
        send_pair(24'hFFFFFF, 24'hFFFFFF);
        send_pair(24'hFFFFFF, 24'h7FFFFF);
        settle();

        // One-pixel window at the origin, 16-bit compare: upper byte ignored
        apply_settings(1'b1, MODE_16BIT, '0, '0, '0, '0);
        send_pair(24'hFF0000, 24'h000000);
        send_pair(24'h00FFFF, 24'hFFFFFF);
        send_pair(24'h123456, 24'h123457);
        send_pair(24'h000000, 24'h008000);
        settle();

        // Inverted window, both axes wrap through the top coordinate
        apply_settings(1'b1, MODE_24BIT, 11'd2046, 11'd2047, 11'd1, 11'd0);
        send_pair(24'h000001, 24'h800001);
        send_pair(24'h000002, 24'h000002);
        send_pair(24'h000003, 24'h000003);
        settle();
        // Switch the compare width mid-window; the scan carries on
        apply_settings(1'b0, MODE_16BIT, '0, '0, '0, '0);
        send_pair(24'h000004, 24'h010004);
        send_pair(24'h000005, 24'hFF0005);
        send_pair(24'h000006, 24'h000007);
        send_pair(24'h000007, 24'h800007);
        send_pair(24'h000008, 24'h000008);
        settle();

        while (pairs_sent < RANDOM_PAIRS)
        begin
            phase++;
            gappy   = ($urandom_range(0, 3) != 0);
            density = densities[$urandom_range(0, 3)];
            mode    = 1'($urandom_range(0, 1));
            if (phase == 3 || phase == 7)
            begin
                // Long row, then long column, each running through the wrap point
                gappy = 1'b0;
                if (phase == 3)
                begin
                    l = coord_t'(MAX_DIM - WRAP_SPAN);
                    r = coord_t'(WRAP_SPAN - 1);
                    t = coord_t'($urandom());
                    b = t;
                end
                else
                begin
                    l = coord_t'($urandom());
                    r = l;
                    t = coord_t'(MAX_DIM - WRAP_SPAN);
                    b = coord_t'(WRAP_SPAN - 1);
                end
                apply_settings(1'b1, mode, l, t, r, b);
                n = 2 * WRAP_SPAN;
                send_random_pairs(n, 2);
                pairs_sent += n;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                apply_settings(1'b0, mode, '0, '0, '0, '0);
                n = $urandom_range(1, 40);
                send_random_pairs(n, density);
                pairs_sent += n;
            end
            else
            begin
                cols = $urandom_range(1, 8);
                rows = $urandom_range(1, 6);
                l = coord_t'($urandom());
                t = coord_t'($urandom());
                case ($urandom_range(0, 7))
                    0: l = '0;
                    1: l = '1;
                    2: t = '0;
                    3: t = '1;
                    default: ;
                endcase
                r = l + coord_t'(cols - 1);
                b = t + coord_t'(rows - 1);
                apply_settings(1'b1, mode, l, t, r, b);
                frames = $urandom_range(1, 4);
                n = frames * cols * rows;
                // Sometimes stop mid-window so the next write cuts the scan short
                if ($urandom_range(0, 3) == 0)
                begin
                    n += $urandom_range(0, cols * rows - 1);
                end
                send_random_pairs(n, density);
                pairs_sent += n;
            end
            settle();
        end

        settle();
        if (check_fails == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
